// ===== rtl/core/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cell engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// Store geometry
	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 128;
	localparam int COL_W     = 8;
	localparam int ROW_W     = 7;
	localparam int NCOL_W    = 9;
	localparam int NROW_W    = 8;
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int CELL_W    = 16;

	localparam int TAB_WIDTH = 8;
	localparam int TAB_SHIFT = $clog2(TAB_WIDTH);

	// Command queue between front and back
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// Character codes
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// Cell after reset: space, fg 7, bg 0
	localparam logic [CELL_W-1:0] RESET_CELL = {4'd0, 4'd7, CH_BLANK};

	// Register indexes
	localparam logic [1:0] REG_NUM_COLS = 2'd0;
	localparam logic [1:0] REG_NUM_ROWS = 2'd1;
	localparam logic [1:0] REG_FG_COLOR = 2'd2;
	localparam logic [1:0] REG_BG_COLOR = 2'd3;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		OP_CHAR  = 3'd0,
		OP_NL    = 3'd1,
		OP_CR    = 3'd2,
		OP_TAB   = 3'd3,
		OP_READ  = 3'd4,
		OP_CLEAR = 3'd5,
		OP_NOP   = 3'd6
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

	// Effective geometry and colours seen by the back end
	typedef struct packed {
		logic [NCOL_W-1:0] eff_cols;
		logic [NROW_W-1:0] eff_rows;
		logic [3:0]        fg;
		logic [3:0]        bg;
	} cfg_t;

	typedef struct packed {
		logic             read_valid;
		logic [7:0]       read_char;
		logic [3:0]       read_fg;
		logic [3:0]       read_bg;
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
	} res_t;

endpackage

// ===== rtl/core/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front
// Input side: takes request words and decodes them into back-end commands.
// ----------------------------------------------------------------------------
module tcce_front (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // char_code, cell_row, cell_col
	input  logic [1:0]            s_tuser,   // req_type
	input  logic                  q_full,
	input  logic                  init_done,
	output logic                  push,
	output tcce_pkg::cmd_t        push_cmd
);

	assign s_tready = !q_full && init_done;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_cmd.ch  = s_tdata[7:0];
		push_cmd.row = s_tdata[14:8];
		push_cmd.col = s_tdata[22:15];
		unique case (s_tuser)
			tcce_pkg::REQ_PUT: begin
				priority if (s_tdata[7:0] == tcce_pkg::CH_NL)
					push_cmd.op = tcce_pkg::OP_NL;
				else if (s_tdata[7:0] == tcce_pkg::CH_CR)
					push_cmd.op = tcce_pkg::OP_CR;
				else if (s_tdata[7:0] == tcce_pkg::CH_TAB)
					push_cmd.op = tcce_pkg::OP_TAB;
				else
					push_cmd.op = tcce_pkg::OP_CHAR;
			end
			tcce_pkg::REQ_READ:  push_cmd.op = tcce_pkg::OP_READ;
			tcce_pkg::REQ_CLEAR: push_cmd.op = tcce_pkg::OP_CLEAR;
			default:             push_cmd.op = tcce_pkg::OP_NOP;
		endcase
	end

endmodule

// ===== rtl/core/tcce_cmd_q.sv =====
// ----------------------------------------------------------------------------
// tcce_cmd_q
// Short command queue decoupling the decoder from the executing back end.
// ----------------------------------------------------------------------------
module tcce_cmd_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcce_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output tcce_pkg::cmd_t q_cmd
);

	tcce_pkg::cmd_t                   entry_q [tcce_pkg::QDEPTH];
	logic [tcce_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [tcce_pkg::QCNT_W-1:0]      count_q;

	function automatic logic [tcce_pkg::QPTR_W-1:0] ptr_inc(
		input logic [tcce_pkg::QPTR_W-1:0] p);
		if (p == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1))
			return '0;
		else
			return p + tcce_pkg::QPTR_W'(1);
	endfunction

	assign full    = (count_q == tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + tcce_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - tcce_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back
// Execution side: owns the cell store and cursor, sequences puts, tabs,
// scrolls, clears and reads, and holds the result word for the output.
// ----------------------------------------------------------------------------
module tcce_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tcce_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  tcce_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           init_done,
	output logic           m_tvalid,
	input  logic           m_tready,
	output tcce_pkg::res_t res
);

	typedef enum logic [8:0] {
		ST_INIT    = 9'b000000001,
		ST_IDLE    = 9'b000000010,
		ST_GLYPH   = 9'b000000100,
		ST_LF      = 9'b000001000,
		ST_SCR_RD  = 9'b000010000,
		ST_SCR_WR  = 9'b000100000,
		ST_FILL    = 9'b001000000,
		ST_RD_CELL = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t                             state_q;
	logic [tcce_pkg::ROW_W-1:0]         cur_row_q, seq_row_q;
	logic [tcce_pkg::COL_W-1:0]         cur_col_q, seq_col_q;
	logic [tcce_pkg::NCOL_W-1:0]        tab_end_q;
	logic [7:0]                         glyph_ch_q;
	logic                               is_put_q;
	logic                               rd_valid_q;
	logic [7:0]                         rd_char_q;
	logic [3:0]                         rd_fg_q, rd_bg_q;
	logic [tcce_pkg::ADDR_W-1:0]        init_addr_q;
	logic                               out_valid_q;
	tcce_pkg::res_t                     out_q;

	// cell store
	logic [tcce_pkg::CELL_W-1:0]        mem [tcce_pkg::DEPTH];
	logic [tcce_pkg::CELL_W-1:0]        rdata_q;
	logic                               mem_we;
	logic [tcce_pkg::ADDR_W-1:0]        waddr, raddr;
	logic [tcce_pkg::CELL_W-1:0]        wdata;

	logic [tcce_pkg::NROW_W-1:0]        rows_m1;
	logic [tcce_pkg::NCOL_W-1:0]        cols_m1;
	logic [tcce_pkg::ROW_W-1:0]         sat_row;
	logic [tcce_pkg::COL_W-1:0]         sat_col;
	logic [tcce_pkg::NCOL_W-1:0]        tab_next, tab_end, glyph_next;
	logic [tcce_pkg::NCOL_W-1:0]        seq_col_nx;
	logic [tcce_pkg::NROW_W-1:0]        seq_row_nx, cur_row_nx;
	logic                               read_hit, out_free;
	logic [tcce_pkg::CELL_W-1:0]        blank_cell;

	assign rows_m1    = cfg.eff_rows - tcce_pkg::NROW_W'(1);
	assign cols_m1    = cfg.eff_cols - tcce_pkg::NCOL_W'(1);
	assign sat_row    = ({1'b0, cur_row_q} >= cfg.eff_rows) ? rows_m1[tcce_pkg::ROW_W-1:0]
	                                                        : cur_row_q;
	assign sat_col    = ({1'b0, cur_col_q} >= cfg.eff_cols) ? cols_m1[tcce_pkg::COL_W-1:0]
	                                                        : cur_col_q;
	// next tab stop from the saturated column, clipped to the width in use
	assign tab_next   = (({1'b0, sat_col} >> tcce_pkg::TAB_SHIFT) + tcce_pkg::NCOL_W'(1))
	                    << tcce_pkg::TAB_SHIFT;
	assign tab_end    = (tab_next > cfg.eff_cols) ? cfg.eff_cols : tab_next;
	assign glyph_next = {1'b0, cur_col_q} + tcce_pkg::NCOL_W'(1);
	assign seq_col_nx = {1'b0, seq_col_q} + tcce_pkg::NCOL_W'(1);
	assign seq_row_nx = {1'b0, seq_row_q} + tcce_pkg::NROW_W'(1);
	assign cur_row_nx = {1'b0, cur_row_q} + tcce_pkg::NROW_W'(1);
	assign read_hit   = ({1'b0, q_cmd.row} < cfg.eff_rows) && ({1'b0, q_cmd.col} < cfg.eff_cols);
	assign out_free   = !out_valid_q || m_tready;
	assign blank_cell = {cfg.bg, cfg.fg, tcce_pkg::CH_BLANK};

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign init_done  = (state_q != ST_INIT);
	assign m_tvalid   = out_valid_q;
	assign res        = out_q;

	// store port control
	always_comb begin
		mem_we = 1'b0;
		waddr  = {seq_row_q, seq_col_q};
		wdata  = blank_cell;
		raddr  = {q_cmd.row, q_cmd.col};
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				waddr  = init_addr_q;
				wdata  = tcce_pkg::RESET_CELL;
			end
			ST_GLYPH: begin
				mem_we = 1'b1;
				waddr  = {cur_row_q, cur_col_q};
				wdata  = {cfg.bg, cfg.fg, glyph_ch_q};
			end
			ST_SCR_RD: raddr = {seq_row_q, seq_col_q};
			ST_SCR_WR: begin
				mem_we = 1'b1;
				waddr  = {seq_row_q - tcce_pkg::ROW_W'(1), seq_col_q};
				wdata  = rdata_q;
			end
			ST_FILL: mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_addr_q <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			seq_row_q   <= '0;
			seq_col_q   <= '0;
			tab_end_q   <= '0;
			glyph_ch_q  <= '0;
			is_put_q    <= 1'b0;
			rd_valid_q  <= 1'b0;
			rd_char_q   <= '0;
			rd_fg_q     <= '0;
			rd_bg_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// in ST_DONE a new word takes the register over directly
			if (out_valid_q && m_tready && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_INIT: begin
					init_addr_q <= init_addr_q + tcce_pkg::ADDR_W'(1);
					if (init_addr_q == tcce_pkg::ADDR_W'(tcce_pkg::DEPTH - 1))
						state_q <= ST_IDLE;
				end

				ST_IDLE: begin
					if (q_valid) begin
						is_put_q   <= (q_cmd.op == tcce_pkg::OP_CHAR) ||
						              (q_cmd.op == tcce_pkg::OP_NL) ||
						              (q_cmd.op == tcce_pkg::OP_CR) ||
						              (q_cmd.op == tcce_pkg::OP_TAB);
						rd_valid_q <= 1'b0;
						rd_char_q  <= '0;
						rd_fg_q    <= '0;
						rd_bg_q    <= '0;
						unique case (q_cmd.op)
							tcce_pkg::OP_CHAR: begin
								cur_row_q  <= sat_row;
								cur_col_q  <= sat_col;
								glyph_ch_q <= q_cmd.ch;
								tab_end_q  <= {1'b0, sat_col} + tcce_pkg::NCOL_W'(1);
								state_q    <= ST_GLYPH;
							end
							tcce_pkg::OP_TAB: begin
								cur_row_q  <= sat_row;
								cur_col_q  <= sat_col;
								glyph_ch_q <= tcce_pkg::CH_BLANK;
								tab_end_q  <= tab_end;
								state_q    <= ST_GLYPH;
							end
							tcce_pkg::OP_NL: begin
								cur_row_q <= sat_row;
								cur_col_q <= sat_col;
								state_q   <= ST_LF;
							end
							tcce_pkg::OP_CR: begin
								cur_row_q <= sat_row;
								cur_col_q <= '0;
								state_q   <= ST_DONE;
							end
							tcce_pkg::OP_READ: begin
								state_q <= read_hit ? ST_RD_CELL : ST_DONE;
							end
							tcce_pkg::OP_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								seq_row_q <= '0;
								seq_col_q <= '0;
								state_q   <= ST_FILL;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end

				ST_GLYPH: begin
					priority if (glyph_next >= cfg.eff_cols) begin
						state_q <= ST_LF;
					end else if (glyph_next < tab_end_q) begin
						cur_col_q <= glyph_next[tcce_pkg::COL_W-1:0];
					end else begin
						cur_col_q <= glyph_next[tcce_pkg::COL_W-1:0];
						state_q   <= ST_DONE;
					end
				end

				ST_LF: begin
					cur_col_q <= '0;
					seq_col_q <= '0;
					priority if (cur_row_nx < cfg.eff_rows) begin
						cur_row_q <= cur_row_nx[tcce_pkg::ROW_W-1:0];
						state_q   <= ST_DONE;
					end else if (cfg.eff_rows == tcce_pkg::NROW_W'(1)) begin
						seq_row_q <= rows_m1[tcce_pkg::ROW_W-1:0];
						state_q   <= ST_FILL;
					end else begin
						seq_row_q <= tcce_pkg::ROW_W'(1);
						state_q   <= ST_SCR_RD;
					end
				end

				ST_SCR_RD: state_q <= ST_SCR_WR;

				ST_SCR_WR: begin
					if (seq_col_nx >= cfg.eff_cols) begin
						seq_col_q <= '0;
						if (seq_row_nx >= cfg.eff_rows) begin
							state_q <= ST_FILL;
						end else begin
							seq_row_q <= seq_row_nx[tcce_pkg::ROW_W-1:0];
							state_q   <= ST_SCR_RD;
						end
					end else begin
						seq_col_q <= seq_col_nx[tcce_pkg::COL_W-1:0];
						state_q   <= ST_SCR_RD;
					end
				end

				ST_FILL: begin
					if (seq_col_nx >= cfg.eff_cols) begin
						seq_col_q <= '0;
						if (seq_row_nx >= cfg.eff_rows)
							state_q <= ST_DONE;
						else
							seq_row_q <= seq_row_nx[tcce_pkg::ROW_W-1:0];
					end else begin
						seq_col_q <= seq_col_nx[tcce_pkg::COL_W-1:0];
					end
				end

				ST_RD_CELL: begin
					rd_valid_q <= 1'b1;
					rd_char_q  <= rdata_q[7:0];
					rd_fg_q    <= rdata_q[11:8];
					rd_bg_q    <= rdata_q[15:12];
					state_q    <= ST_DONE;
				end

				ST_DONE: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.read_valid <= rd_valid_q;
						out_q.read_char  <= rd_char_q;
						out_q.read_fg    <= rd_fg_q;
						out_q.read_bg    <= rd_bg_q;
						out_q.cursor_row <= cur_row_q;
						out_q.cursor_col <= cur_col_q;
						state_q          <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no result leaves before the clearing pass is over
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !out_valid_q)
		else $error("result word during clearing pass");

	// a scroll write always uses the word read the cycle before
	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCR_WR) |-> ($past(state_q) == ST_SCR_RD))
		else $error("scroll write without preceding read");

	// a finished put leaves the cursor inside the area in use
	a_cursor_area: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && is_put_q) |->
		({1'b0, cur_row_q} < cfg.eff_rows && {1'b0, cur_col_q} < cfg.eff_cols))
		else $error("cursor outside area after put");

	// a popped command is always taken up by the sequencer
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != ST_IDLE))
		else $error("command popped but sequencer stayed idle");

endmodule

// ===== rtl/core/text_console_cell_engine_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_engine_core
// Text console: character-cell store, cursor, put/read/clear requests.
// ----------------------------------------------------------------------------
// Usage
//   Requests come in on the s_ stream, one word each; every request gives
//   exactly one result word on the m_ stream (read data plus cursor after
//   the request). Geometry and colours are set through the cfg_ write port;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce.
//   The sequencer handles one command at a time, with one store write per
//   cycle and a read/write pair per scrolled cell. A tab writes blanks up to
//   the next tab stop (at most 8); a wrap or newline on the last row scrolls
//   the area up and blanks the bottom row; a clear blanks every cell in use.
//   Reset: a clearing pass writes all 32768 cells to a space in colour 7 on
//   0, one cell a cycle; s_tready stays low until the pass is over.
//   Stall: a result word waits in the output register; a two-entry command
//   queue keeps taking words until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module text_console_cell_engine_core (
	input  logic        clk,
	input  logic        arst_n,

	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [8:0]  cfg_wdata,

	// requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], cell_row[14:8], cell_col[22:15], 0
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	input  logic        s_tlast,   // end_of_text: end of one write call, no effect

	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_char[7:0], read_fg[11:8], read_bg[15:12],
	                               // cursor_row[22:16], cursor_col[30:23], 0
	output logic [0:0]  m_tuser    // read_valid[0]
);

	logic [tcce_pkg::NCOL_W-1:0] num_cols_q;
	logic [tcce_pkg::NROW_W-1:0] num_rows_q;
	logic [3:0]                  fg_color_q, bg_color_q;
	tcce_pkg::cfg_t              cfg;

	logic                        q_full, q_push, q_pop, q_valid, init_done;
	tcce_pkg::cmd_t              push_cmd, q_cmd;
	tcce_pkg::res_t              res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= tcce_pkg::NCOL_W'(80);
			num_rows_q <= tcce_pkg::NROW_W'(25);
			fg_color_q <= 4'd7;
			bg_color_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tcce_pkg::REG_NUM_COLS: num_cols_q <= cfg_wdata;
				tcce_pkg::REG_NUM_ROWS: num_rows_q <= cfg_wdata[tcce_pkg::NROW_W-1:0];
				tcce_pkg::REG_FG_COLOR: fg_color_q <= cfg_wdata[3:0];
				tcce_pkg::REG_BG_COLOR: bg_color_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, anything past the store acts as the store's size
	always_comb begin
		priority if (num_cols_q == '0)
			cfg.eff_cols = tcce_pkg::NCOL_W'(1);
		else if (num_cols_q > tcce_pkg::NCOL_W'(tcce_pkg::MAX_COLS))
			cfg.eff_cols = tcce_pkg::NCOL_W'(tcce_pkg::MAX_COLS);
		else
			cfg.eff_cols = num_cols_q;
		priority if (num_rows_q == '0)
			cfg.eff_rows = tcce_pkg::NROW_W'(1);
		else if (num_rows_q > tcce_pkg::NROW_W'(tcce_pkg::MAX_ROWS))
			cfg.eff_rows = tcce_pkg::NROW_W'(tcce_pkg::MAX_ROWS);
		else
			cfg.eff_rows = num_rows_q;
		cfg.fg = fg_color_q;
		cfg.bg = bg_color_q;
	end

	// front: decode request words
	tcce_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.init_done (init_done),
		.push      (q_push),
		.push_cmd  (push_cmd)
	);

	// decoupling queue
	tcce_cmd_q u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	// back: store, cursor and sequencer
	tcce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.init_done (init_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tdata = {1'b0, res.cursor_col, res.cursor_row,
	                  res.read_bg, res.read_fg, res.read_char};
	assign m_tuser = res.read_valid;

endmodule

// ===== tb/tb_text_console_cell_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cell_engine_core
// Self-checking bench for the text console cell engine. Put, read, clear and
// unused requests go in on the request stream. A cell-store model predicts
// every result word, and results are checked in order, field by field.
// Directed words come first, then random text runs under several geometries.
// ----------------------------------------------------------------------------
module tb_text_console_cell_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    SETTLE_CYCLES = 32;
	// hard time limit for the whole run, in ns
	localparam longint LIMIT_NS     = 40_000_000;

	// ------------------------------------------------------------------------
	// Console model and in-order result checker
	// ------------------------------------------------------------------------
	class console_scoreboard;
		logic [tcce_pkg::CELL_W-1:0] cells [tcce_pkg::DEPTH];
		int unsigned                 cur_r, cur_c;
		int unsigned                 col_reg, row_reg, fg_reg, bg_reg;
		tcce_pkg::res_t              expected_results [$];
		int                          failures;

		function new();
			col_reg  = 80;
			row_reg  = 25;
			fg_reg   = 7;
			bg_reg   = 0;
			cur_r    = 0;
			cur_c    = 0;
			failures = 0;
			foreach (cells[i]) cells[i] = blank_cell();
		endfunction

		function void set_register(logic [1:0] idx, logic [8:0] value);
			case (idx)
				tcce_pkg::REG_NUM_COLS: col_reg = 32'(value);
				tcce_pkg::REG_NUM_ROWS: row_reg = 32'(value[7:0]);
				tcce_pkg::REG_FG_COLOR: fg_reg  = 32'(value[3:0]);
				tcce_pkg::REG_BG_COLOR: bg_reg  = 32'(value[3:0]);
				default: ;
			endcase
		endfunction

		// zero acts as one, anything above the store size as the maximum
		function int unsigned used_cols();
			if (col_reg < 1) return 1;
			if (col_reg > tcce_pkg::MAX_COLS) return tcce_pkg::MAX_COLS;
			return col_reg;
		endfunction

		function int unsigned used_rows();
			if (row_reg < 1) return 1;
			if (row_reg > tcce_pkg::MAX_ROWS) return tcce_pkg::MAX_ROWS;
			return row_reg;
		endfunction

		function logic [tcce_pkg::CELL_W-1:0] colour_cell(logic [7:0] ch);
			logic [3:0] fg, bg;
			fg = fg_reg[3:0];
			bg = bg_reg[3:0];
			return {bg, fg, ch};
		endfunction

		function logic [tcce_pkg::CELL_W-1:0] blank_cell();
			return colour_cell(tcce_pkg::CH_BLANK);
		endfunction

		function int unsigned cell_ix(int unsigned r, int unsigned c);
			return r * tcce_pkg::MAX_COLS + c;
		endfunction

		function void scroll_up();
			int unsigned rows, cols;
			rows = used_rows();
			cols = used_cols();
			for (int unsigned r = 1; r < rows; r++)
				for (int unsigned c = 0; c < cols; c++)
					cells[cell_ix(r - 1, c)] = cells[cell_ix(r, c)];
			for (int unsigned c = 0; c < cols; c++)
				cells[cell_ix(rows - 1, c)] = blank_cell();
		endfunction

		function void line_feed();
			cur_c = 0;
			if (cur_r + 1 >= used_rows())
				scroll_up();
			else
				cur_r++;
		endfunction

		function void put_glyph(logic [7:0] ch);
			cells[cell_ix(cur_r, cur_c)] = colour_cell(ch);
			cur_c++;
			if (cur_c >= used_cols())
				line_feed();
		endfunction

		function void put_byte(logic [7:0] ch);
			int unsigned tab_stop;
			// cursor left outside after the area shrank: pull it back in
			if (cur_r >= used_rows()) cur_r = used_rows() - 1;
			if (cur_c >= used_cols()) cur_c = used_cols() - 1;
			if (ch == tcce_pkg::CH_NL) begin
				line_feed();
			end else if (ch == tcce_pkg::CH_CR) begin
				cur_c = 0;
			end else if (ch == tcce_pkg::CH_TAB) begin
				tab_stop = (cur_c / tcce_pkg::TAB_WIDTH + 1) * tcce_pkg::TAB_WIDTH;
				if (tab_stop > used_cols()) tab_stop = used_cols();
				repeat (tab_stop - cur_c) put_glyph(tcce_pkg::CH_BLANK);
			end else begin
				put_glyph(ch);
			end
		endfunction

		// apply one accepted request word and queue the result it must give
		function void note_request(tcce_pkg::req_t kind, logic [7:0] ch,
		                           logic [tcce_pkg::ROW_W-1:0] row,
		                           logic [tcce_pkg::COL_W-1:0] col);
			tcce_pkg::res_t              want;
			logic [tcce_pkg::CELL_W-1:0] stored;
			want = '0;
			case (kind)
				tcce_pkg::REQ_PUT: put_byte(ch);
				tcce_pkg::REQ_READ: begin
					if (32'(row) < used_rows() && 32'(col) < used_cols()) begin
						stored          = cells[cell_ix(32'(row), 32'(col))];
						want.read_valid = 1'b1;
						want.read_char  = stored[7:0];
						want.read_fg    = stored[11:8];
						want.read_bg    = stored[15:12];
					end
				end
				tcce_pkg::REQ_CLEAR: begin
					for (int unsigned r = 0; r < used_rows(); r++)
						for (int unsigned c = 0; c < used_cols(); c++)
							cells[cell_ix(r, c)] = blank_cell();
					cur_r = 0;
					cur_c = 0;
				end
				default: ;
			endcase
			want.cursor_row = cur_r[tcce_pkg::ROW_W-1:0];
			want.cursor_col = cur_c[tcce_pkg::COL_W-1:0];
			expected_results.push_back(want);
		endfunction

		function string describe(tcce_pkg::res_t r);
			return $sformatf("valid=%0b char=%02h fg=%0d bg=%0d row=%0d col=%0d",
			                 r.read_valid, r.read_char, r.read_fg, r.read_bg,
			                 r.cursor_row, r.cursor_col);
		endfunction

		function void check_result(logic [31:0] data, logic [0:0] user);
			tcce_pkg::res_t got, want;
			got.read_valid = user[0];
			got.read_char  = data[7:0];
			got.read_fg    = data[11:8];
			got.read_bg    = data[15:12];
			got.cursor_row = data[22:16];
			got.cursor_col = data[30:23];
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result word with nothing expected: %s", describe(got));
			end else begin
				want = expected_results.pop_front();
				if (got.read_valid !== want.read_valid || got.read_char !== want.read_char ||
				    got.read_fg !== want.read_fg || got.read_bg !== want.read_bg ||
				    got.cursor_row !== want.cursor_row ||
				    got.cursor_col !== want.cursor_col) begin
					failures++;
					if (failures <= 10)
						$display("result mismatch: expected %s, actual %s",
						         describe(want), describe(got));
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and its signals
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [8:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // char_code[7:0], cell_row[14:8], cell_col[22:15], 0
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        s_tlast;   // end_of_text
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // read_char[7:0], read_fg[11:8], read_bg[15:12],
	                        // cursor_row[22:16], cursor_col[30:23], 0
	logic [0:0]  m_tuser;   // read_valid[0]

	// idling controls, set by the stimulus, read by both sides
	bit src_gaps;
	bit sink_gaps;
	int long_hold_len;

	console_scoreboard sb;

	text_console_cell_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: takes a word whenever ready and valid meet at an edge,
	// stalls in random bursts, and once holds off for a long stretch so the
	// command queue fills up and the request side sees tready drop.
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				sb.check_result(m_tdata, m_tuser);
			if (stall_left == 0 && long_hold_len != 0) begin
				stall_left    = long_hold_len;
				long_hold_len = 0;
			end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = int'($urandom_range(1, 14));
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side helpers. All are entered and left at a rising edge.
	// ------------------------------------------------------------------------

	// Offer one word, possibly after an idle burst, and hold it until taken.
	// tvalid stays high into the next word when there is no gap.
	task automatic send_request(input tcce_pkg::req_t kind, input logic [7:0] ch,
	                            input logic [tcce_pkg::ROW_W-1:0] row,
	                            input logic [tcce_pkg::COL_W-1:0] col,
	                            input logic eot);
		int gap;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			gap = int'($urandom_range(1, 14));
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, col, row, ch};
		s_tuser  <= kind;
		s_tlast  <= eot;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_request(kind, ch, row, col);
	endtask

	// unused fields carry random noise
	task automatic put_char(input logic [7:0] ch, input logic eot);
		send_request(tcce_pkg::REQ_PUT, ch, 7'($urandom_range(0, 127)),
		             8'($urandom_range(0, 255)), eot);
	endtask

	task automatic read_cell(input int unsigned row, input int unsigned col);
		send_request(tcce_pkg::REQ_READ, 8'($urandom_range(0, 255)), 7'(row), 8'(col),
		             1'($urandom_range(0, 1)));
	endtask

	task automatic clear_screen();
		send_request(tcce_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)),
		             7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
		             1'($urandom_range(0, 1)));
	endtask

	// Stop offering and wait for every outstanding result, then let the
	// block settle before anything touches the registers.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [8:0] value);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	// registers change only with the block idle
	task automatic configure(input int unsigned ncols, input int unsigned nrows,
	                         input int unsigned fgc, input int unsigned bgc);
		wait_results();
		write_register(tcce_pkg::REG_NUM_COLS, 9'(ncols));
		write_register(tcce_pkg::REG_NUM_ROWS, 9'(nrows));
		write_register(tcce_pkg::REG_FG_COLOR, 9'(fgc));
		write_register(tcce_pkg::REG_BG_COLOR, 9'(bgc));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly text runs (one write call each, tlast on its final byte), mixed
	// with reads inside and outside the area, clears and unused requests.
	task automatic run_random_phase(input int unsigned n_items, input bit allow_clear);
		int unsigned sent, pick, run_len;
		logic [7:0]  ch;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				run_len = $urandom_range(1, 12);
				for (int unsigned k = 0; k < run_len; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 70)
						ch = 8'($urandom_range(8'h20, 8'h7E));
					else if (pick < 80)
						ch = tcce_pkg::CH_NL;
					else if (pick < 88)
						ch = tcce_pkg::CH_CR;
					else if (pick < 96)
						ch = tcce_pkg::CH_TAB;
					else
						ch = 8'($urandom_range(0, 255));
					put_char(ch, k == run_len - 1);
				end
				sent += run_len;
			end else begin
				if (pick < 80)
					read_cell($urandom_range(0, sb.used_rows() - 1),
					          $urandom_range(0, sb.used_cols() - 1));
				else if (pick < 88)
					read_cell($urandom_range(0, 127), $urandom_range(0, 255));
				else if (pick < 93 && allow_clear)
					clear_screen();
				else if (pick < 96)
					put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else
					send_request(tcce_pkg::REQ_NONE, 8'($urandom_range(0, 255)),
					             7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
					             1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned items;
		sb            = new();
		src_gaps      = 1'b1;
		sink_gaps     = 1'b1;
		long_hold_len = 0;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_idx   <= '0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		s_tlast   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset holds s_tready low; send_request waits

		// --- directed, reset geometry 80x25, colour 7 on 0 ---
		read_cell(0, 0);                 // reset contents
		read_cell(24, 79);               // last cell in use
		read_cell(25, 0);                // row just outside
		read_cell(0, 80);                // column just outside
		send_request(tcce_pkg::REQ_READ, 8'hFF, 7'h7F, 8'hFF, 1'b1);  // all ones, outside
		put_char(8'h41, 1'b0);
		put_char(8'hFF, 1'b0);
		put_char(8'h00, 1'b0);
		put_char(tcce_pkg::CH_TAB, 1'b0);  // col 3 -> 8
		read_cell(0, 2);
		read_cell(0, 5);                 // blank from the tab
		put_char(tcce_pkg::CH_CR, 1'b0);
		put_char(tcce_pkg::CH_NL, 1'b1);
		send_request(tcce_pkg::REQ_NONE, 8'hFF, 7'h7F, 8'hFF, 1'b1);  // unused: no change
		put_char(8'h42, 1'b1);
		clear_screen();
		read_cell(1, 0);
		put_char(tcce_pkg::CH_NL, 1'b0);
		put_char(8'h43, 1'b0);
		put_char(8'h43, 1'b1);           // cursor now (1,2)

		// --- zero geometry acts as 1x1; cursor left outside the area ---
		configure(0, 0, 15, 15);
		read_cell(0, 0);                 // reports the cursor unsaturated
		put_char(8'h78, 1'b0);           // saturate, store, wrap and scroll
		read_cell(0, 0);
		read_cell(0, 1);
		put_char(tcce_pkg::CH_TAB, 1'b0);  // tab clipped to a single blank
		put_char(tcce_pkg::CH_NL, 1'b1);

		// --- oversized registers act as the full 256x128 store ---
		configure(511, 255, 0, 15);
		read_cell(127, 255);
		put_char(8'h5A, 1'b0);
		put_char(tcce_pkg::CH_TAB, 1'b0);
		read_cell(0, 7);
		put_char(tcce_pkg::CH_CR, 1'b0);
		put_char(tcce_pkg::CH_NL, 1'b1);
		clear_screen();                  // full-store clear, slow
		read_cell(127, 255);
		read_cell(0, 0);

		// --- back-pressure: result side holds off while words keep coming ---
		configure(12, 3, 10, 5);
		src_gaps      = 1'b0;
		long_hold_len = 200;
		for (int k = 0; k < 40; k++)
			put_char((k % 9 == 8) ? tcce_pkg::CH_NL : 8'(8'h61 + k % 26), k == 39);
		src_gaps = 1'b1;

		// --- random phases over varied geometry ---
		for (int p = 0; p < 12; p++) begin
			if (p == 2) begin
				// single wide row: every line feed scrolls
				configure(256, 1, $urandom_range(0, 15), $urandom_range(0, 15));
				items = 60;
			end else if (p == 5) begin
				// single column: every glyph wraps; no clears so the
				// cursor reaches the bottom row and scrolls
				configure(1, 128, $urandom_range(0, 15), $urandom_range(0, 15));
				items = 200;
			end else begin
				configure($urandom_range(1, 24), $urandom_range(1, 6),
				          $urandom_range(0, 15), $urandom_range(0, 15));
				items = 45;
			end
			// last stretch runs flat out on both sides
			if (p == 11) begin
				src_gaps  = 1'b0;
				sink_gaps = 1'b0;
			end
			run_random_phase(items, p != 5);
		end

		wait_results();
		if (sb.failures == 0 && sb.expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
